@@ hdl/ile_pkg.sv @@
// ----------------------------------------------------------------------------
// ile_pkg
// Shared sizes, operation and status codes, and cell control types for the
// indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

    localparam int CAPACITY = 16;
    localparam int ELEM_W   = 32;
    localparam int MASK_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int RES_W    = 32;
    localparam int MPOS_W   = 4;
    localparam int COUNT_W  = 5;
    localparam int STAT_W   = 2;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_FIELD_W = RES_W + 1 + MPOS_W + COUNT_W + STAT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND    = 3'd1;
    localparam logic [OP_W-1:0] OP_REM_LAST  = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_AT    = 3'd3;
    localparam logic [OP_W-1:0] OP_REM_MATCH = 3'd4;
    localparam logic [OP_W-1:0] OP_CONTAINS  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_LOAD,
        CM_LEFT,
        CM_RIGHT
    } t_cell_mode;

    typedef struct packed {
        logic [ELEM_W-1:0]   value;
        logic [MASK_W-1:0]   mask;
    } t_cell_ctl;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
    } t_hit;

endpackage

@@ hdl/ile_cell.sv @@
// ----------------------------------------------------------------------------
// ile_cell
// One list entry: holds, loads, or takes its left or right neighbor, and
// compares its word against the search value under the mask.
// ----------------------------------------------------------------------------
module ile_cell (
    input  logic                          i_clk,
    input  ile_pkg::t_cell_mode           i_mode,
    input  ile_pkg::t_cell_ctl            i_ctl,
    input  logic [ile_pkg::ELEM_W-1:0]    i_left,
    input  logic [ile_pkg::ELEM_W-1:0]    i_right,
    output logic [ile_pkg::ELEM_W-1:0]    o_data,
    output logic                          o_match
);

    logic [ile_pkg::ELEM_W-1:0] r_data;
    logic [ile_pkg::ELEM_W-1:0] n_data;
    logic [ile_pkg::ELEM_W-1:0] w_diff;

    always_comb begin
        case (i_mode)
            ile_pkg::CM_LOAD:  n_data = i_ctl.value;
            ile_pkg::CM_LEFT:  n_data = i_left;
            ile_pkg::CM_RIGHT: n_data = i_right;
            default:           n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign w_diff  = r_data ^ i_ctl.value;
    assign o_match = ((ile_pkg::MASK_W'(w_diff)) & i_ctl.mask) == '0;
    assign o_data  = r_data;

endmodule

@@ hdl/ile_first.sv @@
// ----------------------------------------------------------------------------
// ile_first
// Lowest-index hit finder: isolates the lowest set bit of the hit vector and
// encodes its position.
// ----------------------------------------------------------------------------
module ile_first (
    input  logic [ile_pkg::CAPACITY-1:0] i_hits,
    output ile_pkg::t_hit                o_hit
);

    logic [ile_pkg::CAPACITY-1:0] w_lowest;
    logic [ile_pkg::IDX_W-1:0]    w_idx;

    assign w_lowest = i_hits & (~i_hits + 1'b1);

    always_comb begin
        w_idx = '0;
        for (int b = 0; b < ile_pkg::IDX_W; b++) begin
            for (int i = 0; i < ile_pkg::CAPACITY; i++) begin
                if (((i >> b) & 1) == 1) begin
                    w_idx[b] = w_idx[b] | w_lowest[i];
                end
            end
        end
    end

    assign o_hit.found = |i_hits;
    assign o_hit.idx   = w_idx;

endmodule

@@ hdl/indexed_list_engine.sv @@
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of up to CAPACITY words with insert, append, remove and
// masked search operations, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// An item is registered at the input transfer and executed in the next cycle
// when the result channel is free: every cell compares against the value in
// parallel, the first match is encoded, and the whole row shifts by one place
// at once. Execution waits while a previous result has not been taken, so at
// most one item is held behind an untaken result and the input stalls until
// it executes. The list words have no reset; only the state, the fill count
// and the output valid are cleared and the mask is set to all ones, and
// entries at or above the count are never read. match_mask may be written
// whenever no item is in flight.
// ----------------------------------------------------------------------------
module indexed_list_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ile_pkg::MASK_W-1:0]        i_cfg_wdata,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // operation[2:0], position[7:3], value[39:8]
    input  logic [ile_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // result_value[31:0], found[32], match_position[36:33], count[41:37],
    // status[43:42], zero fill above
    output logic [ile_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [ile_pkg::OP_W-1:0]    r_op;
    logic [ile_pkg::POS_W-1:0]   r_pos;
    logic [ile_pkg::ELEM_W-1:0]  r_val;
    logic [ile_pkg::CNT_W-1:0]   r_count;
    logic [ile_pkg::MASK_W-1:0]  r_mask;

    logic                        r_out_valid;
    logic [ile_pkg::RES_W-1:0]   r_res;
    logic                        r_found;
    logic [ile_pkg::MPOS_W-1:0]  r_mpos;
    logic [ile_pkg::STAT_W-1:0]  r_status;

    logic w_accept;
    logic w_fire;

    logic [ile_pkg::ELEM_W-1:0]   w_data [ile_pkg::CAPACITY];
    logic [ile_pkg::CAPACITY-1:0] w_match;
    logic [ile_pkg::CAPACITY-1:0] w_hits;
    ile_pkg::t_cell_mode          w_mode [ile_pkg::CAPACITY];
    ile_pkg::t_cell_ctl           w_ctl;
    ile_pkg::t_hit                w_hit;

    logic [ile_pkg::CNT_W-1:0]   w_pos;
    logic [ile_pkg::CNT_W-1:0]   w_start;
    logic                        w_full;
    logic                        w_empty;

    logic                        n_do_ins;
    logic                        n_do_shdn;
    logic [ile_pkg::CNT_W-1:0]   n_shift;
    logic                        n_rd_en;
    logic [ile_pkg::IDX_W-1:0]   n_rd_idx;
    logic [ile_pkg::CNT_W-1:0]   n_count;
    logic                        n_found;
    logic [ile_pkg::MPOS_W-1:0]  n_mpos;
    logic [ile_pkg::STAT_W-1:0]  n_status;
    logic [ile_pkg::RES_W-1:0]   n_res;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_fire          = (r_state == S_EXEC) && (!r_out_valid || i_m_axis_tready);

    assign w_pos   = ile_pkg::CNT_W'(r_pos);
    assign w_start = (r_op == ile_pkg::OP_REM_MATCH) ? w_pos : '0;
    assign w_full  = (r_count == ile_pkg::CNT_W'(ile_pkg::CAPACITY));
    assign w_empty = (r_count == '0);

    assign w_ctl.value = r_val;
    assign w_ctl.mask  = r_mask;

    genvar g;
    generate
        for (g = 0; g < ile_pkg::CAPACITY; g++) begin : g_cell
            logic [ile_pkg::ELEM_W-1:0] w_left;
            logic [ile_pkg::ELEM_W-1:0] w_right;

            if (g == 0) begin : g_first
                assign w_left = w_data[g];
            end else begin : g_mid
                assign w_left = w_data[g-1];
            end

            if (g == ile_pkg::CAPACITY - 1) begin : g_last
                assign w_right = w_data[g];
            end else begin : g_inner
                assign w_right = w_data[g+1];
            end

            always_comb begin
                w_mode[g] = ile_pkg::CM_HOLD;
                if (w_fire && n_do_ins) begin
                    if (ile_pkg::CNT_W'(g) == n_shift) begin
                        w_mode[g] = ile_pkg::CM_LOAD;
                    end else if (ile_pkg::CNT_W'(g) > n_shift) begin
                        w_mode[g] = ile_pkg::CM_LEFT;
                    end
                end else if (w_fire && n_do_shdn) begin
                    if (ile_pkg::CNT_W'(g) >= n_shift) begin
                        w_mode[g] = ile_pkg::CM_RIGHT;
                    end
                end
            end

            assign w_hits[g] = w_match[g] && (ile_pkg::CNT_W'(g) < r_count)
                             && (ile_pkg::CNT_W'(g) >= w_start);

            ile_cell u_cell (
                .i_clk   (i_clk),
                .i_mode  (w_mode[g]),
                .i_ctl   (w_ctl),
                .i_left  (w_left),
                .i_right (w_right),
                .o_data  (w_data[g]),
                .o_match (w_match[g])
            );
        end
    endgenerate

    ile_first u_first (
        .i_hits (w_hits),
        .o_hit  (w_hit)
    );

    always_comb begin
        n_do_ins  = 1'b0;
        n_do_shdn = 1'b0;
        n_shift   = '0;
        n_rd_en   = 1'b0;
        n_rd_idx  = '0;
        n_count   = r_count;
        n_found   = 1'b0;
        n_mpos    = '0;
        n_status  = ile_pkg::ST_OK;
        case (r_op)
            ile_pkg::OP_INSERT: begin
                if (w_full) begin
                    n_status = ile_pkg::ST_FULL;
                end else if (w_pos > r_count) begin
                    n_status = ile_pkg::ST_RANGE;
                end else begin
                    n_do_ins = 1'b1;
                    n_shift  = w_pos;
                    n_count  = r_count + 1'b1;
                end
            end
            ile_pkg::OP_APPEND: begin
                if (w_full) begin
                    n_status = ile_pkg::ST_FULL;
                end else begin
                    n_do_ins = 1'b1;
                    n_shift  = r_count;
                    n_count  = r_count + 1'b1;
                end
            end
            ile_pkg::OP_REM_LAST: begin
                if (w_empty) begin
                    n_status = ile_pkg::ST_EMPTY;
                end else begin
                    n_rd_en  = 1'b1;
                    n_rd_idx = ile_pkg::IDX_W'(r_count - 1'b1);
                    n_count  = r_count - 1'b1;
                end
            end
            ile_pkg::OP_REM_AT: begin
                if (w_empty) begin
                    n_status = ile_pkg::ST_EMPTY;
                end else if (w_pos >= r_count) begin
                    n_status = ile_pkg::ST_RANGE;
                end else begin
                    n_rd_en   = 1'b1;
                    n_rd_idx  = ile_pkg::IDX_W'(w_pos);
                    n_do_shdn = 1'b1;
                    n_shift   = w_pos;
                    n_count   = r_count - 1'b1;
                end
            end
            ile_pkg::OP_REM_MATCH: begin
                if (w_empty) begin
                    n_status = ile_pkg::ST_EMPTY;
                end else if (w_pos > r_count) begin
                    n_status = ile_pkg::ST_RANGE;
                end else if (w_hit.found) begin
                    n_found   = 1'b1;
                    n_mpos    = ile_pkg::MPOS_W'(w_hit.idx);
                    n_rd_en   = 1'b1;
                    n_rd_idx  = w_hit.idx;
                    n_do_shdn = 1'b1;
                    n_shift   = ile_pkg::CNT_W'(w_hit.idx);
                    n_count   = r_count - 1'b1;
                end
            end
            ile_pkg::OP_CONTAINS: begin
                if (w_empty) begin
                    n_status = ile_pkg::ST_EMPTY;
                end else if (w_hit.found) begin
                    n_found = 1'b1;
                    n_mpos  = ile_pkg::MPOS_W'(w_hit.idx);
                end
            end
            default: begin
                n_status = ile_pkg::ST_OK;
            end
        endcase
        n_res = n_rd_en ? ile_pkg::RES_W'(w_data[n_rd_idx]) : '0;
    end

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = w_accept ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = w_fire ? S_IDLE : S_EXEC;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_mask      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_s_axis_tdata[2:0];
            r_pos <= i_s_axis_tdata[7:3];
            r_val <= ile_pkg::ELEM_W'(i_s_axis_tdata[39:8]);
        end
        if (w_fire) begin
            r_res    <= n_res;
            r_found  <= n_found;
            r_mpos   <= n_mpos;
            r_status <= n_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{ile_pkg::OUT_PAD_W{1'b0}}, r_status,
                              ile_pkg::COUNT_W'(r_count), r_mpos, r_found, r_res};

endmodule

@@ hdl/ile_checker.sv @@
// ----------------------------------------------------------------------------
// ile_checker
// Port-level checks for the indexed list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ile_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [ile_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    logic [ile_pkg::RES_W-1:0]   w_res;
    logic                        w_found;
    logic [ile_pkg::MPOS_W-1:0]  w_mpos;
    logic [ile_pkg::COUNT_W-1:0] w_count;
    logic [ile_pkg::STAT_W-1:0]  w_status;

    assign w_res    = o_m_axis_tdata[31:0];
    assign w_found  = o_m_axis_tdata[32];
    assign w_mpos   = o_m_axis_tdata[36:33];
    assign w_count  = o_m_axis_tdata[41:37];
    assign w_status = o_m_axis_tdata[43:42];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> w_count <= ile_pkg::COUNT_W'(ile_pkg::CAPACITY))
        else $error("count above capacity");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_found |->
            w_status == ile_pkg::ST_OK && ile_pkg::COUNT_W'(w_mpos) <= w_count)
        else $error("match reported with bad status or position");

    a_error_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_status != ile_pkg::ST_OK |-> !w_found && w_res == '0)
        else $error("error result carries data");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_status == ile_pkg::ST_FULL |->
            w_count == ile_pkg::COUNT_W'(ile_pkg::CAPACITY))
        else $error("full reported below capacity");

endmodule

bind indexed_list_engine ile_checker u_ile_checker (.*);

@@ tb/indexed_list_engine_tb.sv @@
// ----------------------------------------------------------------------------
// indexed_list_engine_tb
// Self-checking bench for the indexed list engine. List commands stream in
// while a local copy of the list predicts each reply, and replies are checked
// field by field. Both ports idle at random. The match mask is changed between
// phases: all ones, none, then partial and random masks.
// ----------------------------------------------------------------------------
module indexed_list_engine_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ile_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [ile_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STUCK_LIMIT     = 3000;
    localparam int MAX_REPORTS     = 100;

    typedef struct {
        logic [ile_pkg::OP_W-1:0]  op;
        logic [ile_pkg::POS_W-1:0] pos;
        logic [ile_pkg::VAL_W-1:0] value;
    } t_list_cmd;

    typedef struct {
        logic [ile_pkg::RES_W-1:0]   value;
        logic                        found;
        logic [ile_pkg::MPOS_W-1:0]  mpos;
        logic [ile_pkg::COUNT_W-1:0] count;
        logic [ile_pkg::STAT_W-1:0]  status;
    } t_list_reply;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [ile_pkg::MASK_W-1:0]      i_cfg_wdata = '0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [ile_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    logic [ile_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;

    t_list_cmd   pending_cmds[$];
    t_list_reply expected_replies[$];
    t_list_cmd   offered;

    logic [ile_pkg::ELEM_W-1:0] list_cells[ile_pkg::CAPACITY];
    int                         list_len = 0;
    logic [ile_pkg::MASK_W-1:0] match_bits = '1;

    logic [ile_pkg::VAL_W-1:0] value_pool[8];
    int  err_count = 0;
    int  src_gap = 0;
    int  sink_stall = 0;
    bit  src_steady = 1'b0;
    bit  sink_steady = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_seen = 1'b0;

    indexed_list_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int list_find(int start, logic [ile_pkg::VAL_W-1:0] v);
        int i;
        for (i = start; i < list_len; i++) begin
            if (((list_cells[i] ^ v) & match_bits) == '0) return i;
        end
        return -1;
    endfunction

    function automatic logic [ile_pkg::ELEM_W-1:0] list_take(int p);
        logic [ile_pkg::ELEM_W-1:0] v;
        int i;
        v = list_cells[p];
        for (i = p; i + 1 < list_len; i++) list_cells[i] = list_cells[i + 1];
        list_len--;
        return v;
    endfunction

    function automatic t_list_reply list_apply(t_list_cmd c);
        t_list_reply r;
        int hit;
        int i;
        int p;
        r = '{default: '0};
        p = int'(c.pos);
        case (c.op)
            ile_pkg::OP_INSERT: begin
                if (list_len >= ile_pkg::CAPACITY) begin
                    r.status = ile_pkg::ST_FULL;
                end else if (p > list_len) begin
                    r.status = ile_pkg::ST_RANGE;
                end else begin
                    for (i = list_len; i > p; i--) list_cells[i] = list_cells[i - 1];
                    list_cells[p] = c.value;
                    list_len++;
                end
            end
            ile_pkg::OP_APPEND: begin
                if (list_len >= ile_pkg::CAPACITY) begin
                    r.status = ile_pkg::ST_FULL;
                end else begin
                    list_cells[list_len] = c.value;
                    list_len++;
                end
            end
            ile_pkg::OP_REM_LAST: begin
                if (list_len == 0) begin
                    r.status = ile_pkg::ST_EMPTY;
                end else begin
                    list_len--;
                    r.value = list_cells[list_len];
                end
            end
            ile_pkg::OP_REM_AT: begin
                if (list_len == 0) r.status = ile_pkg::ST_EMPTY;
                else if (p >= list_len) r.status = ile_pkg::ST_RANGE;
                else r.value = list_take(p);
            end
            ile_pkg::OP_REM_MATCH: begin
                if (list_len == 0) begin
                    r.status = ile_pkg::ST_EMPTY;
                end else if (p > list_len) begin
                    r.status = ile_pkg::ST_RANGE;
                end else begin
                    hit = list_find(p, c.value);
                    if (hit >= 0) begin
                        r.found = 1'b1;
                        r.mpos  = ile_pkg::MPOS_W'(hit);
                        r.value = list_take(hit);
                    end
                end
            end
            ile_pkg::OP_CONTAINS: begin
                if (list_len == 0) begin
                    r.status = ile_pkg::ST_EMPTY;
                end else begin
                    hit = list_find(0, c.value);
                    if (hit >= 0) begin
                        r.found = 1'b1;
                        r.mpos  = ile_pkg::MPOS_W'(hit);
                    end
                end
            end
            default: ;
        endcase
        r.count = ile_pkg::COUNT_W'(list_len);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (err_count < MAX_REPORTS)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                     want);
        err_count++;
    endtask

    task automatic check_reply(logic [ile_pkg::OUT_TDATA_W-1:0] word);
        t_list_reply want;
        if (expected_replies.size() == 0) begin
            report_mismatch("unexpected transfer", word[31:0], '0);
        end else begin
            want = expected_replies.pop_front();
            if (word[31:0] !== want.value)
                report_mismatch("result_value", word[31:0], want.value);
            if (word[32] !== want.found)
                report_mismatch("found", 32'(word[32]), 32'(want.found));
            if (word[36:33] !== want.mpos)
                report_mismatch("match_position", 32'(word[36:33]), 32'(want.mpos));
            if (word[41:37] !== want.count)
                report_mismatch("count", 32'(word[41:37]), 32'(want.count));
            if (word[43:42] !== want.status)
                report_mismatch("status", 32'(word[43:42]), 32'(want.status));
        end
    endtask

    // Command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_replies.push_back(list_apply(offered));
                src_gap = src_steady ? 0 : idle_gap();
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    offered = pending_cmds.pop_front();
                    i_s_axis_tdata  <= {offered.value, offered.pos, offered.op};
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Reply monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            sink_stall = 0;
            hold_seen = hold_req;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) check_reply(o_m_axis_tdata);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                sink_stall = HOLD_OFF_CYCLES;
            end
            if (sink_stall > 0) begin
                sink_stall--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (!sink_steady) sink_stall = idle_gap();
            end
        end
    end

    initial begin : watchdog
        int stuck;
        stuck = 0;
        wait (i_rst_n === 1'b1);
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                    || (pending_cmds.size() == 0 && expected_replies.size() == 0
                        && !i_s_axis_tvalid))
                stuck = 0;
            else
                stuck++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic queue_cmd(logic [ile_pkg::OP_W-1:0] op, int pos,
                             logic [ile_pkg::VAL_W-1:0] value);
        t_list_cmd c;
        c.op    = op;
        c.pos   = ile_pkg::POS_W'(pos);
        c.value = value;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || i_s_axis_tvalid || expected_replies.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_mask(logic [ile_pkg::MASK_W-1:0] m);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        match_bits = m;
        @(negedge i_clk);
    endtask

    task automatic queue_random(int n, int fill_pct, int drain_pct);
        logic [ile_pkg::OP_W-1:0]  op;
        logic [ile_pkg::VAL_W-1:0] v;
        int r;
        int k;
        value_pool[0] = '0;
        value_pool[1] = '1;
        for (k = 2; k < 8; k++) value_pool[k] = $urandom;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 3) op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
            else if (r < 3 + fill_pct)
                op = $urandom_range(0, 1) ? ile_pkg::OP_APPEND : ile_pkg::OP_INSERT;
            else if (r < 3 + fill_pct + drain_pct)
                case ($urandom_range(0, 2))
                    0: op = ile_pkg::OP_REM_LAST;
                    1: op = ile_pkg::OP_REM_AT;
                    default: op = ile_pkg::OP_REM_MATCH;
                endcase
            else op = $urandom_range(0, 1) ? ile_pkg::OP_CONTAINS : ile_pkg::OP_REM_MATCH;
            r = $urandom_range(0, 99);
            if (r < 50) v = value_pool[$urandom_range(0, 7)];
            else if (r < 62) v = value_pool[$urandom_range(0, 7)] ^ (32'd1 << $urandom_range(0, 31));
            else v = $urandom;
            queue_cmd(op, ($urandom_range(0, 99) < 85) ? $urandom_range(0, 16)
                                                     : $urandom_range(0, 31), v);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_mask('1);

        queue_cmd(ile_pkg::OP_CONTAINS, 0, 32'h0);
        queue_cmd(ile_pkg::OP_REM_LAST, 0, 32'h0);
        queue_cmd(ile_pkg::OP_REM_AT, 0, 32'h0);
        queue_cmd(ile_pkg::OP_REM_MATCH, 0, 32'h0);
        queue_cmd(ile_pkg::OP_INSERT, 1, 32'hDEAD_BEEF);
        queue_cmd(ile_pkg::OP_INSERT, 0, 32'h0000_0000);
        queue_cmd(ile_pkg::OP_APPEND, 0, 32'hFFFF_FFFF);
        queue_cmd(ile_pkg::OP_INSERT, 1, 32'h1234_5678);
        queue_cmd(ile_pkg::OP_INSERT, 3, 32'hA5A5_5A5A);
        queue_cmd(ile_pkg::OP_CONTAINS, 31, 32'h1234_5678);
        queue_cmd(ile_pkg::OP_CONTAINS, 0, 32'h8765_4321);
        queue_cmd(ile_pkg::OP_REM_MATCH, 4, 32'hA5A5_5A5A);
        queue_cmd(ile_pkg::OP_REM_MATCH, 31, 32'hA5A5_5A5A);
        queue_cmd(ile_pkg::OP_REM_MATCH, 1, 32'hFFFF_FFFF);
        queue_cmd(ile_pkg::OP_REM_AT, 3, 32'h0);
        queue_cmd(ile_pkg::OP_REM_AT, 0, 32'hFFFF_FFFF);
        queue_cmd(OP_SPARE_A, 31, 32'hFFFF_FFFF);
        queue_cmd(OP_SPARE_B, 0, 32'h0);
        queue_cmd(ile_pkg::OP_REM_LAST, 31, 32'h0);
        queue_cmd(ile_pkg::OP_INSERT, 31, 32'h0F0F_0F0F);
        wait_drained();

        queue_random(150, 70, 10);
        wait_drained();

        queue_random(150, 35, 35);
        repeat (30) @(negedge i_clk);
        hold_req = ~hold_req;
        wait_drained();

        write_mask('0);
        queue_random(100, 35, 35);
        wait_drained();

        write_mask(32'h0000_00FF);
        src_steady  = 1'b1;
        sink_steady = 1'b1;
        queue_random(150, 40, 30);
        wait_drained();
        src_steady  = 1'b0;
        sink_steady = 1'b0;

        write_mask(32'hFFFF_0000);
        queue_random(100, 15, 60);
        wait_drained();

        write_mask(32'h8000_0001);
        queue_random(150, 35, 35);
        wait_drained();

        write_mask($urandom);
        queue_random(100, 55, 20);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (expected_replies.size() != 0)
            report_mismatch("replies never seen", 32'(expected_replies.size()), 0);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
